// ===== hw/rtl/dsl_pkg.sv =====
// Shared constants, register indexes and controller/datapath interface types.
package dsl_pkg;

    localparam int DATA_W = 32;
    localparam int WIDE_W = 64;
    localparam int GUESS_W = 16;
    localparam int CFG_ADDR_W = 2;

    localparam int NEWTON_STEPS_DEF = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DIVISOR  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_GUESS = CFG_ADDR_W'(1);

    localparam logic [DATA_W-1:0]  GAIN_RESET  = 32'd5889581;
    localparam logic [GUESS_W-1:0] GUESS_RESET = 16'd300;
    localparam logic [WIDE_W-1:0]  ROOT_LIMIT  = 64'd2147483647;
    localparam logic [DATA_W-1:0]  MOST_NEG    = 32'h8000_0000;

    typedef struct packed {
        logic load_input;
        logic div_start_q;
        logic take_q;
        logic div_start_newton;
        logic newton_update;
        logic set_res_zero;
        logic set_res_root;
        logic load_out;
    } dsl_cmd_t;

    typedef struct packed {
        logic special;
        logic q_zero;
        logic div_done;
        logic converged;
        logic out_free;
    } dsl_status_t;

endpackage

// ===== hw/rtl/dsl_divider.sv =====
// Restoring radix-2 divider, 64-bit dividend and divisor, one quotient bit per cycle.
module dsl_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [dsl_pkg::WIDE_W-1:0] dividend,
    input  logic [dsl_pkg::WIDE_W-1:0] divisor,
    output logic                      done,
    output logic [dsl_pkg::WIDE_W-1:0] quotient
);

    localparam int W = dsl_pkg::WIDE_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;

    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so the difference fits in W bits.
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/dsl_datapath.sv =====
// Datapath: configuration registers, operand and estimate registers, divider, output register.
module dsl_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dsl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dsl_pkg::DATA_W-1:0]      cfg_wdata,
    input  logic signed [dsl_pkg::DATA_W-1:0] s_drive_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [dsl_pkg::DATA_W-1:0] m_drive_out,
    input  dsl_pkg::dsl_cmd_t               cmd,
    output dsl_pkg::dsl_status_t            status
);

    localparam int DW = dsl_pkg::DATA_W;
    localparam int WW = dsl_pkg::WIDE_W;

    logic [DW-1:0]                gain_reg;
    logic [dsl_pkg::GUESS_W-1:0]  guess_reg;

    logic [DW-1:0] raw_reg;
    logic          neg_reg;
    logic [DW-1:0] mag_reg;
    logic [WW-1:0] q_reg;
    logic [WW-1:0] a_reg;
    logic [DW-1:0] res_reg;
    logic [DW-1:0] out_reg;
    logic          out_valid_reg, out_valid_next;

    logic          div_start;
    logic          div_done;
    logic [WW-1:0] div_dividend;
    logic [WW-1:0] div_divisor;
    logic [WW-1:0] div_quotient;

    logic [WW-1:0] sum;
    logic [WW-1:0] a_step;
    logic [DW-1:0] root_sat;
    logic [WW-1:0] a_init;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= dsl_pkg::GAIN_RESET;
            guess_reg <= dsl_pkg::GUESS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                dsl_pkg::REG_GAIN_DIVISOR:  gain_reg  <= cfg_wdata;
                dsl_pkg::REG_INITIAL_GUESS: guess_reg <= cfg_wdata[dsl_pkg::GUESS_W-1:0];
                default: ;
            endcase
        end
    end

    assign div_start    = cmd.div_start_q | cmd.div_start_newton;
    assign div_dividend = cmd.div_start_q ? {mag_reg, {DW{1'b0}}} : q_reg;
    assign div_divisor  = cmd.div_start_q ? {{(WW-DW){1'b0}}, gain_reg} : a_reg;

    dsl_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Newton step (a + q / a) >> 1 with the sum kept to 64 bits.
    assign sum    = a_reg + div_quotient;
    assign a_step = {1'b0, sum[WW-1:1]};
    assign a_init = (guess_reg != '0) ? {{(WW-dsl_pkg::GUESS_W){1'b0}}, guess_reg}
                                      : WW'(1);
    assign root_sat = (a_reg > dsl_pkg::ROOT_LIMIT) ? dsl_pkg::ROOT_LIMIT[DW-1:0]
                                                    : a_reg[DW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_input) begin
            raw_reg <= s_drive_in;
            neg_reg <= s_drive_in[DW-1];
            mag_reg <= s_drive_in[DW-1] ? (~s_drive_in + DW'(1)) : s_drive_in;
        end
        if (cmd.take_q) begin
            q_reg <= div_quotient;
            a_reg <= a_init;
        end else if (cmd.newton_update) begin
            a_reg <= a_step;
        end
        if (cmd.set_res_zero) begin
            res_reg <= '0;
        end else if (cmd.set_res_root) begin
            res_reg <= neg_reg ? (~root_sat + DW'(1)) : root_sat;
        end
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.special   = (raw_reg == '0) || (raw_reg == dsl_pkg::MOST_NEG)
                              || (gain_reg == '0);
    assign status.q_zero    = (div_quotient == '0);
    assign status.div_done  = div_done;
    assign status.converged = (a_step == a_reg);
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_valid     = out_valid_reg;
    assign m_drive_out = out_reg;

endmodule

// ===== hw/rtl/dsl_ctrl.sv =====
// Controller state machine: sequences the gain division, the Newton steps and the result hand-off.
module dsl_ctrl #(
    parameter int NEWTON_STEPS = dsl_pkg::NEWTON_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dsl_pkg::dsl_status_t status,
    output dsl_pkg::dsl_cmd_t    cmd
);

    localparam int CNT_W = $clog2(NEWTON_STEPS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV_Q  = 3'd2;
    localparam logic [2:0] ST_QCHK   = 3'd3;
    localparam logic [2:0] ST_DIV_N  = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_ROOT   = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             last_step;

    assign last_step = (step_reg == CNT_W'(NEWTON_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_input = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.special) begin
                    cmd.set_res_zero = 1'b1;
                    state_next       = ST_FINISH;
                end else begin
                    cmd.div_start_q = 1'b1;
                    state_next      = ST_DIV_Q;
                end
            end
            ST_DIV_Q: begin
                if (status.div_done) begin
                    if (status.q_zero) begin
                        cmd.set_res_zero = 1'b1;
                        state_next       = ST_FINISH;
                    end else begin
                        cmd.take_q = 1'b1;
                        step_next  = '0;
                        state_next = ST_QCHK;
                    end
                end
            end
            ST_QCHK: begin
                cmd.div_start_newton = 1'b1;
                state_next           = ST_DIV_N;
            end
            ST_DIV_N: begin
                if (status.div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // A step that leaves the estimate unchanged ends the iteration early.
                cmd.newton_update = 1'b1;
                step_next         = step_reg + CNT_W'(1);
                if (status.converged || last_step) begin
                    state_next = ST_ROOT;
                end else begin
                    state_next = ST_QCHK;
                end
            end
            ST_ROOT: begin
                cmd.set_res_root = 1'b1;
                state_next       = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== hw/rtl/drive_sqrt_linearizer_core.sv =====
// From the accepting edge to m_valid: a zero or most negative input or a zero gain gives
// a zero result with no division, and a zero quotient from the gain division gives zero;
// otherwise k Newton steps run (1 to NEWTON_STEPS), each on the shared bit-serial 64-bit divider.
// One request is taken at a time, as s_ready is high only while idle; a held result stalls
// the next request only once that request's own result is ready to leave.
// Reset clears control state and loads the register defaults.
// Top level: linearizer core joining controller and datapath.
module drive_sqrt_linearizer_core #(
    parameter int NEWTON_STEPS = dsl_pkg::NEWTON_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [dsl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [dsl_pkg::DATA_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [dsl_pkg::DATA_W-1:0] s_drive_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [dsl_pkg::DATA_W-1:0] m_drive_out
);

    dsl_pkg::dsl_cmd_t    cmd;
    dsl_pkg::dsl_status_t status;

    dsl_ctrl #(
        .NEWTON_STEPS (NEWTON_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dsl_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_drive_in  (s_drive_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive_out (m_drive_out),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
